@@ rtl/fhct_pkg.sv @@
// Shared types, constants and result codes of the flow hit counter table.
`timescale 1ns / 1ps
package fhct_pkg;

	// Table geometry default
	localparam int TABLE_ENTRIES_DEF = 32;

	// Configuration register defaults and map
	localparam logic [7:0] DEFAULT_PROTOCOL = 8'd6;
	localparam int         APB_ADDR_W       = 3;
	localparam int         APB_DATA_W       = 32;
	localparam logic       REG_TRACKED_PROTO = 1'b0;

	// Payload widths
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int PROTO_W  = 8;
	localparam int COUNT_W  = 64;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_UNTRACKED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_HIT       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Five-field flow key
	typedef struct packed {
		logic [ADDR_W-1:0]  src_addr;
		logic [ADDR_W-1:0]  dst_addr;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
		logic [PROTO_W-1:0] ip_protocol;
	} flow_key_t;

	// One table entry as held in the entry memory
	typedef struct packed {
		flow_key_t          key;
		logic [COUNT_W-1:0] count;
	} flow_entry_t;

	localparam int ENTRY_W = $bits(flow_entry_t);

endpackage

@@ rtl/fhct_if.sv @@
// Valid/ready channel interfaces for packet headers and flow results.
`timescale 1ns / 1ps
interface fhct_req_if;
	logic                           valid;
	logic                           ready;
	logic [fhct_pkg::ADDR_W-1:0]    src_addr;
	logic [fhct_pkg::ADDR_W-1:0]    dst_addr;
	logic [fhct_pkg::PORT_W-1:0]    sport;
	logic [fhct_pkg::PORT_W-1:0]    dport;
	logic [fhct_pkg::PROTO_W-1:0]   ip_protocol;

	modport source (output valid, src_addr, dst_addr, sport, dport, ip_protocol,
		input ready);
	modport sink (input valid, src_addr, dst_addr, sport, dport, ip_protocol,
		output ready);
endinterface

interface fhct_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [fhct_pkg::STATUS_W-1:0]  status;
	logic [fhct_pkg::COUNT_W-1:0]   flow_count;
	logic [fhct_pkg::INDEX_W-1:0]   entry_index;

	modport source (output valid, status, flow_count, entry_index, input ready);
	modport sink (input valid, status, flow_count, entry_index, output ready);
endinterface

@@ rtl/fhct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fhct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/fhct_cfg.sv @@
// APB-style register block holding the tracked protocol number.
`timescale 1ns / 1ps
module fhct_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fhct_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fhct_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fhct_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [fhct_pkg::PROTO_W-1:0]    tracked_protocol
);
	import fhct_pkg::*;

	logic [PROTO_W-1:0] tracked_q;
	logic               sel_tracked;
	logic               wr_en;

	// Word index is paddr[2]; byte offset bits are ignored
	assign sel_tracked = (paddr[2] == REG_TRACKED_PROTO);
	assign wr_en       = psel && penable && pwrite && pready;
	assign pready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= DEFAULT_PROTOCOL;
		end else if (wr_en && sel_tracked) begin
			tracked_q <= pwdata[PROTO_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (sel_tracked) begin
			prdata = {{(APB_DATA_W-PROTO_W){1'b0}}, tracked_q};
		end
	end

	assign tracked_protocol = tracked_q;

endmodule

@@ rtl/flow_hit_counter_table.sv @@
// Top level: exact-match flow table with per-flow packet counters.
//
//  channel  dir   handshake            payload
//  req      in    valid/ready          src_addr dst_addr sport dport ip_protocol
//  rsp      out   valid/ready          status flow_count entry_index
//  apb      in    psel/penable/pready  paddr pwdata prdata (tracked_protocol at 0x0)
//
// One packet is in work at a time. An untracked packet skips the scan; a tracked one
// is compared with the stored entries in slot order, up to the hit slot or, on a miss,
// through the fill count; the entry memory gives one key per cycle on its read port.
// Entries fill from slot 0 upward and are never freed, so a fill counter stands in for
// valid bits and reset needs no clearing pass. A result waits in the output register
// while the next packet is already accepted; a stalled rsp holds the engine before
// its next result.
`timescale 1ns / 1ps
module flow_hit_counter_table #(
	parameter int TABLE_ENTRIES = fhct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fhct_req_if.sink                        req,
	fhct_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fhct_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fhct_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fhct_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import fhct_pkg::*;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int WIDE_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

	// Engine states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic [PROTO_W-1:0]  tracked_protocol;
	flow_key_t           in_key;
	flow_key_t           key_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_d;
	logic [FILL_W-1:0]   fill_q;
	logic                fill_inc;
	logic                table_free;
	logic                last_scan;
	logic                key_match;

	// Entry memory ports
	logic                we;
	logic [IDX_W-1:0]    waddr;
	flow_entry_t         wentry;
	logic                re;
	logic [IDX_W-1:0]    raddr;
	flow_entry_t         rentry;
	logic [COUNT_W-1:0]  count_inc;

	// Pending result
	logic                res_load;
	logic [STATUS_W-1:0] res_status_d;
	logic [COUNT_W-1:0]  res_count_d;
	logic [IDX_W-1:0]    res_slot_d;
	logic [WIDE_W-1:0]   res_slot_wide;
	logic [STATUS_W-1:0] res_status_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic [INDEX_W-1:0]  res_index_q;

	// Output register
	logic                out_load;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [INDEX_W-1:0]  out_index_q;

	fhct_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.tracked_protocol (tracked_protocol)
	);

	fhct_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_entries (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.re    (re),
		.raddr (raddr),
		.rdata (rentry)
	);

	assign in_key = '{src_addr:    req.src_addr,
	                  dst_addr:    req.dst_addr,
	                  sport:       req.sport,
	                  dport:       req.dport,
	                  ip_protocol: req.ip_protocol};

	assign req.ready  = (state_q == S_IDLE);
	assign table_free = (fill_q < FILL_MAX);
	assign last_scan  = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
	assign key_match  = (rentry.key == key_q);
	assign count_inc  = rentry.count + COUNT_W'(1);

	// Scan reads slot 0 on accept, then the slot after the one being compared
	assign re    = (state_q == S_IDLE) || (state_q == S_SCAN);
	assign raddr = (state_q == S_IDLE) ? '0 : idx_q + IDX_W'(1);

	// Lookup, update and insert decisions
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		we           = 1'b0;
		waddr        = fill_q[IDX_W-1:0];
		wentry       = '{key: key_q, count: COUNT_W'(1)};
		fill_inc     = 1'b0;
		res_load     = 1'b0;
		res_status_d = ST_UNTRACKED;
		res_count_d  = '0;
		res_slot_d   = '0;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					idx_d = '0;
					if (req.ip_protocol != tracked_protocol) begin
						res_load = 1'b1;
						state_d  = S_RESULT;
					end else if (fill_q == '0) begin
						// Empty table: insert straight into slot 0
						we           = 1'b1;
						wentry       = '{key: in_key, count: COUNT_W'(1)};
						fill_inc     = 1'b1;
						res_load     = 1'b1;
						res_status_d = ST_INSERTED;
						res_count_d  = COUNT_W'(1);
						state_d      = S_RESULT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (key_match) begin
					// Hit: write back the bumped count
					we           = 1'b1;
					waddr        = idx_q;
					wentry       = '{key: key_q, count: count_inc};
					res_load     = 1'b1;
					res_status_d = ST_HIT;
					res_count_d  = count_inc;
					res_slot_d   = idx_q;
					state_d      = S_RESULT;
				end else if (last_scan) begin
					res_load = 1'b1;
					state_d  = S_RESULT;
					if (table_free) begin
						we           = 1'b1;
						fill_inc     = 1'b1;
						res_status_d = ST_INSERTED;
						res_count_d  = COUNT_W'(1);
						res_slot_d   = fill_q[IDX_W-1:0];
					end else begin
						res_status_d = ST_FULL;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_slot_wide = WIDE_W'(res_slot_d);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (fill_inc) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Packet key and pending result
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q <= in_key;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_count_q  <= res_count_d;
			res_index_q  <= res_slot_wide[INDEX_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
			out_index_q  <= res_index_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.flow_count  = out_count_q;
	assign rsp.entry_index = out_index_q;

endmodule
